FILE: sv/five_tuple_first_match_classifier_core_defines.svh
// assertion macros for the five-tuple classifier core
// expects clk_i and rst_ni in the scope of each use
`ifndef FIVE_TUPLE_FIRST_MATCH_CLASSIFIER_CORE_DEFINES_SVH
`define FIVE_TUPLE_FIRST_MATCH_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FTC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ftc_pkg.sv
// types, codes and match functions of the five-tuple classifier
// no dependencies; imported by the core
package ftc_pkg;

  // stream widths
  localparam int RULE_W     = 149;
  localparam int S_TDATA_W  = 152;
  localparam int S_TUSER_W  = 2;
  localparam int RULE_IDX_W = 10;
  localparam int M_TDATA_W  = 16;
  localparam int M_TUSER_W  = 2;

  // command codes
  localparam logic [S_TUSER_W-1:0] CMD_CLEAR    = 2'd0;
  localparam logic [S_TUSER_W-1:0] CMD_APPEND   = 2'd1;
  localparam logic [S_TUSER_W-1:0] CMD_CLASSIFY = 2'd2;

  // status codes
  localparam logic [M_TUSER_W-1:0] ST_DONE    = 2'd0;
  localparam logic [M_TUSER_W-1:0] ST_MATCH   = 2'd1;
  localparam logic [M_TUSER_W-1:0] ST_NOMATCH = 2'd2;
  localparam logic [M_TUSER_W-1:0] ST_FULL    = 2'd3;

  // rule entry, laid out as the input word (src_addr in the low bits)
  typedef struct packed {
    logic        proto_any;
    logic [7:0]  proto;
    logic [15:0] dport_hi;
    logic [15:0] dport_lo;
    logic [15:0] sport_hi;
    logic [15:0] sport_lo;
    logic [5:0]  dst_len;
    logic [31:0] dst_addr;
    logic [5:0]  src_len;
    logic [31:0] src_addr;
  } rule_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_e;

  // prefix compare; zero length matches all, lengths above 32 act as 32
  function automatic logic prefix_hit(logic [31:0] base, logic [5:0] len,
                                      logic [31:0] addr);
    logic [5:0]  l;
    logic [31:0] m;
    l = (len > 6'd32) ? 6'd32 : len;
    if (l == 6'd0) begin
      m = '0;
    end else begin
      m = 32'hFFFF_FFFF << (6'd32 - l);
    end
    return (base & m) == (addr & m);
  endfunction

  // all five fields; key carries the packet in the low-bound fields
  function automatic logic rule_hit(rule_t r, rule_t key);
    logic s_ok;
    logic d_ok;
    logic sp_ok;
    logic dp_ok;
    logic p_ok;
    s_ok  = prefix_hit(r.src_addr, r.src_len, key.src_addr);
    d_ok  = prefix_hit(r.dst_addr, r.dst_len, key.dst_addr);
    sp_ok = (r.sport_lo <= key.sport_lo) && (key.sport_lo <= r.sport_hi);
    dp_ok = (r.dport_lo <= key.dport_lo) && (key.dport_lo <= r.dport_hi);
    p_ok  = r.proto_any || (r.proto == key.proto);
    return s_ok && d_ok && sp_ok && dp_ok && p_ok;
  endfunction

endpackage

FILE: sv/five_tuple_first_match_classifier_core.sv
// five-tuple first-match classifier: rule table in ram, linear search
// depends on ftc_pkg, ftc_ram and five_tuple_first_match_classifier_core_defines.svh
//
// Usage:
//   Input words arrive on s_axis: tuser carries the command (clear, append,
//   classify), tdata the rule or packet fields. Each word yields exactly one
//   output word on m_axis: tuser the status, tdata the matching rule index.
//   Clear and append answer one cycle after acceptance. A classify reads the
//   rules in order from the rule ram and stops at the first hit; a miss
//   reads all rule_count rules (at most MAX_RULES). The registered ram read
//   port sets the rate of about one rule per cycle.
//   One command is in work at a time; s_axis_tready_o is high only when no
//   search runs and the output register is empty or being drained.
//   If the receiver stalls, the result waits in the output register and
//   no further command is taken.
//   Reset empties the table (rule count zero) and drops any pending result;
//   ram contents are not cleared and never read past the rule count.
module five_tuple_first_match_classifier_core #(
  parameter int MAX_RULES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // src_addr[31:0], src_len[37:32], dst_addr[69:38], dst_len[75:70],
  // sport_lo[91:76], sport_hi[107:92], dport_lo[123:108], dport_hi[139:124],
  // proto[147:140], proto_any[148], zero pad[151:149]
  input  logic [ftc_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // command[1:0]
  input  logic [ftc_pkg::S_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // rule_index[9:0], zero pad[15:10]
  output logic [ftc_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // status[1:0]
  output logic [ftc_pkg::M_TUSER_W-1:0]  m_axis_tuser_o
);

  import ftc_pkg::*;

  `include "five_tuple_first_match_classifier_core_defines.svh"

  localparam int AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);

  fsm_e                  state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      iss_q, iss_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [AW-1:0]         chk_idx_q, chk_idx_d;
  rule_t                 key_q, key_d;
  logic                  out_vld_q, out_vld_d;
  logic [M_TUSER_W-1:0]  out_status_q, out_status_d;
  logic [RULE_IDX_W-1:0] out_idx_q, out_idx_d;

  logic                  s_acc;
  logic                  table_full;
  logic                  ram_we;
  logic                  ram_re;
  logic [RULE_W-1:0]     ram_rdata;
  rule_t                 rd_rule;
  logic                  hit;
  logic                  miss_done;
  logic [AW+RULE_IDX_W-1:0] idx_ext;

  // rule table
  ftc_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i[RULE_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // handshake and search status
  assign s_axis_tready_o = (state_q == FSM_IDLE) && (!out_vld_q || m_axis_tready_i);
  assign s_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign table_full = (cnt_q == CNT_W'(MAX_RULES));
  assign rd_rule    = rule_t'(ram_rdata);
  assign hit        = (state_q == FSM_SCAN) && chk_vld_q && rule_hit(rd_rule, key_q);
  assign miss_done  = (state_q == FSM_SCAN) && !chk_vld_q && (iss_q == cnt_q);
  assign ram_re     = (state_q == FSM_SCAN) && !hit && (iss_q < cnt_q);
  assign ram_we     = s_acc && (s_axis_tuser_i == CMD_APPEND) && !table_full;
  assign idx_ext    = {{RULE_IDX_W{1'b0}}, chk_idx_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (s_acc && (s_axis_tuser_i == CMD_CLASSIFY)) begin
          state_d = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (hit || miss_done) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    cnt_d        = cnt_q;
    iss_d        = iss_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    key_d        = key_q;
    out_vld_d    = out_vld_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;

    unique case (state_q)
      FSM_IDLE: begin
        if (s_acc) begin
          unique case (s_axis_tuser_i)
            CMD_CLEAR: begin
              cnt_d        = '0;
              out_vld_d    = 1'b1;
              out_status_d = ST_DONE;
              out_idx_d    = '0;
            end
            CMD_APPEND: begin
              out_vld_d = 1'b1;
              out_idx_d = '0;
              if (table_full) begin
                out_status_d = ST_FULL;
              end else begin
                cnt_d        = cnt_q + CNT_W'(1);
                out_status_d = ST_DONE;
              end
            end
            CMD_CLASSIFY: begin
              key_d = rule_t'(s_axis_tdata_i[RULE_W-1:0]);
              iss_d = '0;
            end
            default: begin
              out_vld_d    = 1'b1;
              out_status_d = ST_DONE;
              out_idx_d    = '0;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        if (ram_re) begin
          iss_d     = iss_q + CNT_W'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = iss_q[AW-1:0];
        end
        if (hit) begin
          out_vld_d    = 1'b1;
          out_status_d = ST_MATCH;
          out_idx_d    = idx_ext[RULE_IDX_W-1:0];
        end else if (miss_done) begin
          out_vld_d    = 1'b1;
          out_status_d = ST_NOMATCH;
          out_idx_d    = '0;
        end
      end
      default: begin
        out_vld_d = out_vld_q && !m_axis_tready_i;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      cnt_q     <= '0;
      iss_q     <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      iss_q     <= iss_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q    <= chk_idx_d;
    key_q        <= key_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
  end

  // output stream
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - RULE_IDX_W){1'b0}}, out_idx_q};

  // checks
  `FTC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_RULES), "rule count above table size")
  `FTC_ASSERT_IMPL(a_iss_bound, state_q == FSM_SCAN, iss_q <= cnt_q, "search index past rule count")
  `FTC_ASSERT_IMPL(a_no_take_in_scan, state_q == FSM_SCAN, !s_axis_tready_o, "input taken during search")
  `FTC_ASSERT_NEXT(a_classify_scans, s_acc && (s_axis_tuser_i == CMD_CLASSIFY), state_q == FSM_SCAN, "classify did not start a search")
  `FTC_ASSERT_NEXT(a_clear_empties, s_acc && (s_axis_tuser_i == CMD_CLEAR), cnt_q == '0, "clear left rules in the table")

endmodule

FILE: sv/ftc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies; holds the rule table of the classifier
module ftc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
